[hdl/rhsv_pkg.sv]
// Shared types and constants of the RGB to HSV pixel converter.
package rhsv_pkg;

  // Fractional quotient bits produced by each divider stage, and how many stages.
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = 4;
  // Two front stages (extremes, then numerator and span) plus the divider stages.
  localparam int PIPE_DEPTH = 2 + DIV_STAGES;

  localparam int CHAN_W = 8;
  localparam int HUE_W  = 16;
  localparam int SAT_W  = 17;
  localparam int SPAN_W = 11;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Working state of the two long divisions as it travels down the pipe.
  typedef struct packed {
    logic [CHAN_W-1:0] sat_div;
    logic [CHAN_W-1:0] sat_rem;
    logic [SAT_W-1:0]  sat_q;
    logic [SPAN_W-1:0] hue_div;
    logic [SPAN_W-1:0] hue_rem;
    logic [HUE_W-1:0]  hue_q;
    logic [CHAN_W-1:0] brightness;
  } div_t;

endpackage

[hdl/rhsv_pixel_if.sv]
// Pixel input channel: blue, green and red bytes with a valid/ready handshake.
interface rhsv_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink (input valid, input blue, input green, input red, output ready);
endinterface

[hdl/rhsv_hsv_if.sv]
// Result channel: hue, saturation and brightness with a valid/ready handshake.
interface rhsv_hsv_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [16:0] saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness, input ready);
  modport sink (input valid, input hue, input saturation, input brightness, output ready);
endinterface

[hdl/rhsv_div_stage.sv]
// One pipelined stage of the saturation and hue restoring dividers.
module rhsv_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  rhsv_pkg::div_t    up_d,
  input  logic              up_valid,
  output logic              up_ready,
  output rhsv_pkg::div_t    dn_d,
  output logic              dn_valid,
  input  logic              dn_ready
);

  rhsv_pkg::div_t d_r, d_nxt;
  logic           valid_r, valid_nxt;
  logic           load;

  // Each step doubles the remainder and subtracts the divisor when it fits.
  // The remainder always stays below the divisor, so the widths never grow.
  always_comb begin
    logic [rhsv_pkg::CHAN_W:0] sat_sh;
    logic [rhsv_pkg::SPAN_W:0] hue_sh;
    d_nxt = up_d;
    for (int k = 0; k < rhsv_pkg::DIV_BITS; k++) begin
      sat_sh = {d_nxt.sat_rem, 1'b0};
      if (sat_sh >= {1'b0, d_nxt.sat_div}) begin
        sat_sh        = sat_sh - {1'b0, d_nxt.sat_div};
        d_nxt.sat_q   = {d_nxt.sat_q[rhsv_pkg::SAT_W-2:0], 1'b1};
      end else begin
        d_nxt.sat_q   = {d_nxt.sat_q[rhsv_pkg::SAT_W-2:0], 1'b0};
      end
      d_nxt.sat_rem = sat_sh[rhsv_pkg::CHAN_W-1:0];

      hue_sh = {d_nxt.hue_rem, 1'b0};
      if (hue_sh >= {1'b0, d_nxt.hue_div}) begin
        hue_sh        = hue_sh - {1'b0, d_nxt.hue_div};
        d_nxt.hue_q   = {d_nxt.hue_q[rhsv_pkg::HUE_W-2:0], 1'b1};
      end else begin
        d_nxt.hue_q   = {d_nxt.hue_q[rhsv_pkg::HUE_W-2:0], 1'b0};
      end
      d_nxt.hue_rem = hue_sh[rhsv_pkg::SPAN_W-1:0];
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign load      = up_ready;
  assign valid_nxt = load ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_d     = d_r;
  assign dn_valid = valid_r;

endmodule

[hdl/rgb_to_hsv_pixel.sv]
// Top level of the pipelined RGB to HSV pixel converter.
// Throughput: one pixel per cycle while the output is ready; every stage has its own valid bit
// and loads whenever it is empty or its successor takes its content, so bubbles close up.
// The six stages are max/min, numerator and span, then four divider stages
// that each settle four quotient bits of both divisions.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
module rgb_to_hsv_pixel (
  input  logic              clk,
  input  logic              rst_n,
  rhsv_pixel_if.sink        in_pix,
  rhsv_hsv_if.source        out_hsv
);

  localparam int CW = rhsv_pkg::CHAN_W;
  localparam int SW = rhsv_pkg::SPAN_W;
  localparam int NS = rhsv_pkg::DIV_STAGES;

  // ---------------------------------------------------------------------------
  // Stage 1: largest and smallest channel, chroma and the hue sector.
  // Ties for the largest channel go to red first, then green.
  // ---------------------------------------------------------------------------
  logic                  s1_valid_r;
  logic                  s1_ready;
  logic [CW-1:0]         s1_max_r, s1_max_nxt;
  logic [CW-1:0]         s1_delta_r, s1_delta_nxt;
  rhsv_pkg::sector_t     s1_sect_r, s1_sect_nxt;
  logic [CW-1:0]         s1_red_r, s1_green_r, s1_blue_r;

  logic                  s2_valid_r;
  logic                  s2_ready;

  always_comb begin
    logic [CW-1:0] mn;
    s1_max_nxt = in_pix.red;
    mn         = in_pix.red;
    if (in_pix.green > s1_max_nxt) s1_max_nxt = in_pix.green;
    if (in_pix.blue  > s1_max_nxt) s1_max_nxt = in_pix.blue;
    if (in_pix.green < mn) mn = in_pix.green;
    if (in_pix.blue  < mn) mn = in_pix.blue;
    s1_delta_nxt = s1_max_nxt - mn;
    priority if (s1_max_nxt == in_pix.red) begin
      s1_sect_nxt = rhsv_pkg::SECT_RED;
    end else if (s1_max_nxt == in_pix.green) begin
      s1_sect_nxt = rhsv_pkg::SECT_GREEN;
    end else begin
      s1_sect_nxt = rhsv_pkg::SECT_BLUE;
    end
  end

  assign s1_ready     = !s1_valid_r || s2_ready;
  assign in_pix.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_pix.valid) begin
      s1_max_r   <= s1_max_nxt;
      s1_delta_r <= s1_delta_nxt;
      s1_sect_r  <= s1_sect_nxt;
      s1_red_r   <= in_pix.red;
      s1_green_r <= in_pix.green;
      s1_blue_r  <= in_pix.blue;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: hue numerator and span (six times chroma), and the setup of both
  // long divisions. The hue numerator is the sector's channel difference plus
  // the sector offset in units of chroma; only the red sector can go negative,
  // and then one full span is added so the quotient wraps modulo one turn.
  // A grey pixel (zero chroma) and a black pixel (zero maximum) would divide by
  // zero; they get a divisor of one over a zero remainder, which yields zero.
  // The saturation quotient's integer bit is one exactly when chroma equals a nonzero
  // maximum, i.e. the smallest channel is zero and the pixel is not black.
  // ---------------------------------------------------------------------------
  rhsv_pkg::div_t        s2_d_r, s2_d_nxt;
  logic [NS:0]           dv_valid;
  logic [NS:0]           dv_ready;
  rhsv_pkg::div_t        dv_d [NS+1];

  always_comb begin
    logic signed [SW:0] diff;
    logic signed [SW:0] num;
    logic [SW-1:0]      offs;
    logic [SW-1:0]      span;
    logic               grey;
    logic               black;
    logic               sat_int;
    span  = {1'b0, s1_delta_r, 2'b00} + {2'b00, s1_delta_r, 1'b0};
    grey  = (s1_delta_r == '0);
    black = (s1_max_r == '0);
    unique case (s1_sect_r)
      rhsv_pkg::SECT_RED: begin
        diff = $signed({4'b0000, s1_green_r}) - $signed({4'b0000, s1_blue_r});
        offs = '0;
      end
      rhsv_pkg::SECT_GREEN: begin
        diff = $signed({4'b0000, s1_blue_r}) - $signed({4'b0000, s1_red_r});
        offs = {2'b00, s1_delta_r, 1'b0};
      end
      default: begin
        diff = $signed({4'b0000, s1_red_r}) - $signed({4'b0000, s1_green_r});
        offs = {1'b0, s1_delta_r, 2'b00};
      end
    endcase
    num = diff + $signed({1'b0, offs});
    if (num[SW]) begin
      num = num + $signed({1'b0, span});
    end
    sat_int = !black && (s1_delta_r == s1_max_r);

    s2_d_nxt.sat_div    = black ? CW'(1) : s1_max_r;
    s2_d_nxt.sat_rem    = sat_int ? '0 : s1_delta_r;
    s2_d_nxt.sat_q      = {{(rhsv_pkg::SAT_W-1){1'b0}}, sat_int};
    s2_d_nxt.hue_div    = grey ? SW'(1) : span;
    s2_d_nxt.hue_rem    = grey ? '0 : num[SW-1:0];
    s2_d_nxt.hue_q      = '0;
    s2_d_nxt.brightness = s1_max_r;
  end

  assign s2_ready = !s2_valid_r || dv_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_d_r <= s2_d_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3 to 6: the restoring dividers, four quotient bits per stage for
  // both the saturation and the hue. The last stage drives the output beat.
  // ---------------------------------------------------------------------------
  assign dv_d[0]      = s2_d_r;
  assign dv_valid[0]  = s2_valid_r;
  assign dv_ready[NS] = out_hsv.ready;

  for (genvar i = 0; i < NS; i++) begin : g_div
    rhsv_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_d     (dv_d[i]),
      .up_valid (dv_valid[i]),
      .up_ready (dv_ready[i]),
      .dn_d     (dv_d[i+1]),
      .dn_valid (dv_valid[i+1]),
      .dn_ready (dv_ready[i+1])
    );
  end

  assign out_hsv.valid      = dv_valid[NS];
  assign out_hsv.hue        = dv_d[NS].hue_q;
  assign out_hsv.saturation = dv_d[NS].sat_q;
  assign out_hsv.brightness = dv_d[NS].brightness;

endmodule

[hdl/rhsv_chk.sv]
// Port-level checker of the RGB to HSV pixel converter, bound to the top level.
module rhsv_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_hue,
  input logic [16:0] out_saturation,
  input logic [7:0]  out_brightness
);

  logic [3:0] occ_r, occ_nxt;

  // Beats inside the pipe: accepted at the input and not yet taken at the output.
  always_comb begin
    occ_nxt = occ_r;
    if (in_valid && in_ready)   occ_nxt = occ_nxt + 4'd1;
    if (out_valid && out_ready) occ_nxt = occ_nxt - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hue) &&
      $stable(out_saturation) && $stable(out_brightness))
    else $error("stalled output beat changed");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 4'(rhsv_pkg::PIPE_DEPTH) && (!out_valid || occ_r != 4'd0))
    else $error("pipeline holds more beats than stages or emits an unrequested beat");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled although the output drains");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_saturation <= 17'h10000)
    else $error("saturation above one");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == 8'd0 |-> out_saturation == 17'd0 && out_hue == 16'd0)
    else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel rhsv_chk u_rhsv_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_pix.valid),
  .in_ready       (in_pix.ready),
  .out_valid      (out_hsv.valid),
  .out_ready      (out_hsv.ready),
  .out_hue        (out_hsv.hue),
  .out_saturation (out_hsv.saturation),
  .out_brightness (out_hsv.brightness)
);
